/* src/bdh_pkg.sv */
// Shared types and constants for the button debounce and hold event block.
// No dependencies; bdh_step, the top level and the bench refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package bdh_pkg;

  localparam int NUM_BUTTONS = 64;
  localparam int BTN_AW      = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int IDX_W       = 6;
  localparam int TICK_W      = 14;
  localparam int DEB_W       = 8;
  localparam int HOLD_W      = 12;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 16;

  localparam logic [DEB_W-1:0]  DEB_RESET  = DEB_W'(5);
  localparam logic [HOLD_W-1:0] HOLD_RESET = HOLD_W'(100);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD     = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    EV_NONE         = 3'd0,
    EV_PRESS        = 3'd1,
    EV_RELEASE      = 3'd2,
    EV_HOLD         = 3'd3,
    EV_REPEAT       = 3'd4,
    EV_LATE_RELEASE = 3'd5
  } event_kind_t;

  // Per-button stored state
  typedef struct packed {
    logic signed [TICK_W-1:0] tick;
    logic                     shift;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

/* src/bdh_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bdh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                              clk,
  input  wire logic                              we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                  wdata,
  input  wire logic                              re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* src/bdh_step.sv */
// Next-state and event logic for one poll of one button.
// Depends on bdh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bdh_step (
  input  wire bdh_pkg::entry_t                   cur,
  input  wire logic                              pin_level,
  input  wire logic                              shift_now,
  input  wire logic [bdh_pkg::DEB_W-1:0]         debounce,
  input  wire logic [bdh_pkg::HOLD_W-1:0]        hold,
  output bdh_pkg::entry_t                        nxt,
  output bdh_pkg::event_kind_t                   ev
);

  logic signed [bdh_pkg::TICK_W-1:0] d_s;
  logic signed [bdh_pkg::TICK_W-1:0] h_s;
  logic signed [bdh_pkg::TICK_W-1:0] c;

  assign d_s = signed'(bdh_pkg::TICK_W'(debounce));
  assign h_s = signed'(bdh_pkg::TICK_W'(hold));
  assign c   = cur.tick;

  always_comb begin
    nxt = cur;
    ev  = bdh_pkg::EV_NONE;
    if (c == '0) begin
      if (pin_level) begin
        nxt.shift = shift_now;
        nxt.tick  = bdh_pkg::TICK_W'(1);
        ev        = bdh_pkg::EV_PRESS;
      end
    end else if (c > 0 && c < d_s) begin
      nxt.tick = c + bdh_pkg::TICK_W'(1);
    end else if (c >= d_s && c < h_s) begin
      if (!pin_level) begin
        nxt.tick = -d_s;
        ev       = bdh_pkg::EV_RELEASE;
      end else begin
        nxt.tick = c + bdh_pkg::TICK_W'(1);
      end
    end else if (c == h_s) begin
      nxt.tick = c + bdh_pkg::TICK_W'(1);
      ev       = bdh_pkg::EV_HOLD;
    end else if (c > h_s) begin
      if (pin_level) begin
        ev = bdh_pkg::EV_REPEAT;
      end else begin
        nxt.tick = -d_s;
        ev       = bdh_pkg::EV_LATE_RELEASE;
      end
    end else begin
      // lockout: count back up towards idle
      nxt.tick = c + bdh_pkg::TICK_W'(1);
    end
  end

endmodule

`default_nettype wire

/* src/button_debounce_hold_events_top.sv */
// Top level of the button debounce and hold event block.
// Depends on bdh_pkg, bdh_ram and bdh_step.
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake              Word
// in       sink       in_valid / in_ready    button_index, pin_level, shift_now
// out      source     out_valid / out_ready  button_echo, event_kind, shift_latched
// cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One word in, one word out; a new word may be accepted every cycle while out is not stalled.
// The per-button state RAM read is registered, then the step logic updates it and
// loads the result register in the same cycle.
// A poll of the button updated in the cycle before takes the forwarded value.
// Reset clears the per-button valid bits, so every button starts idle at once.
// A stall on out holds stage one; in_ready is high only while stage one is empty
// or advancing, so at most one more word goes in before the input stalls.

module button_debounce_hold_events_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [bdh_pkg::IDX_W-1:0]         button_index,
  input  wire logic                              pin_level,
  input  wire logic                              shift_now,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic      [bdh_pkg::IDX_W-1:0]         button_echo,
  output logic      [2:0]                        event_kind,
  output logic                                   shift_latched,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [bdh_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [bdh_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int WIDE_W  = bdh_pkg::BTN_AW + bdh_pkg::IDX_W;
  localparam int NUM_VLD = bdh_pkg::NUM_BUTTONS;

  // configuration registers
  logic [bdh_pkg::DEB_W-1:0]  debounce;
  logic [bdh_pkg::HOLD_W-1:0] hold;

  // stage one: word waiting on the RAM read
  logic                        s1_valid;
  logic [bdh_pkg::IDX_W-1:0]   s1_index;
  logic                        s1_pin;
  logic                        s1_shift;
  logic                        s1_in_range;
  logic                        s1_vld;
  logic                        s1_fwd;
  bdh_pkg::entry_t             s1_fwd_data;

  logic [NUM_VLD-1:0]          vld;

  logic                        in_fire;
  logic                        s1_fire;
  logic [WIDE_W-1:0]           in_wide;
  logic [WIDE_W-1:0]           s1_wide;
  logic [bdh_pkg::BTN_AW-1:0]  in_addr;
  logic [bdh_pkg::BTN_AW-1:0]  s1_addr;
  logic                        in_in_range;
  logic [bdh_pkg::ENTRY_W-1:0] ram_rdata;
  bdh_pkg::entry_t             cur;
  bdh_pkg::entry_t             nxt;
  bdh_pkg::event_kind_t        ev;
  logic                        wr_en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce <= bdh_pkg::DEB_RESET;
      hold     <= bdh_pkg::HOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == bdh_pkg::CFG_DEBOUNCE) begin
        debounce <= cfg_data[bdh_pkg::DEB_W-1:0];
      end else if (cfg_index == bdh_pkg::CFG_HOLD) begin
        hold <= cfg_data[bdh_pkg::HOLD_W-1:0];
      end
    end
  end

  // handshakes: stage one advances whenever the result register is free
  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;
  assign in_fire  = in_valid && in_ready;

  assign in_wide     = WIDE_W'(button_index);
  assign s1_wide     = WIDE_W'(s1_index);
  assign in_addr     = in_wide[bdh_pkg::BTN_AW-1:0];
  assign s1_addr     = s1_wide[bdh_pkg::BTN_AW-1:0];
  assign in_in_range = in_wide < WIDE_W'(bdh_pkg::NUM_BUTTONS);

  assign wr_en = s1_fire && s1_in_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // capture the word; forward the state written this cycle to a poll of the same button
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_index    <= button_index;
      s1_pin      <= pin_level;
      s1_shift    <= shift_now;
      s1_in_range <= in_in_range;
      s1_vld      <= vld[in_addr];
      s1_fwd      <= wr_en && (s1_addr == in_addr);
      s1_fwd_data <= nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[s1_addr] <= 1'b1;
    end
  end

  bdh_ram #(
    .WIDTH (bdh_pkg::ENTRY_W),
    .DEPTH (bdh_pkg::NUM_BUTTONS)
  ) u_state_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_addr),
    .wdata (nxt),
    .re    (in_fire),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  // a button never written since reset reads as idle
  always_comb begin
    if (s1_fwd) begin
      cur = s1_fwd_data;
    end else if (s1_vld) begin
      cur = bdh_pkg::entry_t'(ram_rdata);
    end else begin
      cur = '0;
    end
  end

  bdh_step u_step (
    .cur       (cur),
    .pin_level (s1_pin),
    .shift_now (s1_shift),
    .debounce  (debounce),
    .hold      (hold),
    .nxt       (nxt),
    .ev        (ev)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      button_echo   <= s1_index;
      event_kind    <= s1_in_range ? ev : bdh_pkg::EV_NONE;
      shift_latched <= s1_in_range && nxt.shift;
    end
  end

`ifndef SYNTHESIS
  a_fwd_same_button: assert property (@(posedge clk) disable iff (rst)
    (in_fire && wr_en && (s1_addr == in_addr)) |=> s1_fwd)
    else $error("poll of the button just written did not take the forwarded state");

  a_press_loads_one: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && ev == bdh_pkg::EV_PRESS) |-> (nxt.tick == bdh_pkg::TICK_W'(1)))
    else $error("press did not start the counter at one");

  a_release_lockout: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && (ev == bdh_pkg::EV_RELEASE || ev == bdh_pkg::EV_LATE_RELEASE))
      |-> (nxt.tick == -signed'(bdh_pkg::TICK_W'(debounce))))
    else $error("release did not load the lockout");

  a_tick_floor: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (nxt.tick >= -signed'(bdh_pkg::TICK_W'(255))))
    else $error("counter fell below the lockout floor");

  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> (vld == '0))
    else $error("valid bits not cleared by reset");
`endif

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// Self-checking bench for button_debounce_hold_events_top: a per-button tick predictor
// in a small scoreboard class, with valid/ready drivers, random idling and back-pressure.
// Depends on bdh_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT      = 1_000_000;
  localparam int LONG_HOLD_CYCLES = 120;
  localparam int DRAIN_CYCLES     = 8;

  // One expected output word
  typedef struct {
    logic [bdh_pkg::IDX_W-1:0] btn;
    bdh_pkg::event_kind_t      kind;
    logic                      shifted;
  } event_word_t;

  // Predict the event of every poll from a private copy of the per-button
  // counters and the two registers; hold the expected words in order.
  class debounce_scoreboard;
    logic signed [bdh_pkg::TICK_W-1:0] tick [bdh_pkg::NUM_BUTTONS];
    bit                                press_shift [bdh_pkg::NUM_BUTTONS];
    logic [bdh_pkg::DEB_W-1:0]         debounce;
    logic [bdh_pkg::HOLD_W-1:0]        hold;
    event_word_t                       expected_events [$];
    int                                errors;
    int                                polls;
    int                                checked;
    int                                kind_seen [6];

    function new();
      for (int i = 0; i < bdh_pkg::NUM_BUTTONS; i++) begin
        tick[i]        = '0;
        press_shift[i] = 1'b0;
      end
      debounce = bdh_pkg::DEB_RESET;
      hold     = bdh_pkg::HOLD_RESET;
      errors   = 0;
      polls    = 0;
      checked  = 0;
      for (int k = 0; k < 6; k++) kind_seen[k] = 0;
    endfunction

    function void write_reg(logic [bdh_pkg::CFG_IDX_W-1:0] idx,
                            logic [bdh_pkg::CFG_DATA_W-1:0] data);
      if (idx == bdh_pkg::CFG_DEBOUNCE) debounce = data[bdh_pkg::DEB_W-1:0];
      else if (idx == bdh_pkg::CFG_HOLD) hold = data[bdh_pkg::HOLD_W-1:0];
    endfunction

    function void predict_poll(logic [bdh_pkg::IDX_W-1:0] btn, logic pin, logic shift_in);
      int                   c;
      int                   d;
      int                   h;
      bdh_pkg::event_kind_t kind;
      event_word_t          w;
      kind = bdh_pkg::EV_NONE;
      w.shifted = 1'b0;
      if (int'(btn) < bdh_pkg::NUM_BUTTONS) begin
        c = int'(tick[btn]);
        d = int'(debounce);
        h = int'(hold);
        // The order of the tests matters when hold sits below debounce
        if (c == 0) begin
          if (pin) begin
            press_shift[btn] = shift_in;
            kind = bdh_pkg::EV_PRESS;
            c = 1;
          end
        end else if (c > 0 && c < d) begin
          c++;
        end else if (c >= d && c < h) begin
          if (!pin) begin
            kind = bdh_pkg::EV_RELEASE;
            c = -d;
          end else begin
            c++;
          end
        end else if (c == h) begin
          kind = bdh_pkg::EV_HOLD;
          c++;
        end else if (c > h) begin
          if (pin) begin
            kind = bdh_pkg::EV_REPEAT;
          end else begin
            kind = bdh_pkg::EV_LATE_RELEASE;
            c = -d;
          end
        end else begin
          c++;
        end
        tick[btn] = bdh_pkg::TICK_W'(c);
        w.shifted = press_shift[btn];
      end
      w.btn  = btn;
      w.kind = kind;
      expected_events.push_back(w);
      polls++;
    endfunction

    function void check_event(logic [bdh_pkg::IDX_W-1:0] btn, logic [2:0] kind,
                              logic shifted);
      event_word_t w;
      if (expected_events.size() == 0) begin
        $error("unexpected event word: button %0d kind %0d shifted %0d", btn, kind, shifted);
        errors++;
      end else begin
        w = expected_events.pop_front();
        checked++;
        kind_seen[w.kind]++;
        if (btn !== w.btn) begin
          $error("button_echo: expected %0d, got %0d", w.btn, btn);
          errors++;
        end
        if (kind !== w.kind) begin
          $error("event_kind: expected %0d, got %0d", w.kind, kind);
          errors++;
        end
        if (shifted !== w.shifted) begin
          $error("shift_latched: expected %0d, got %0d", w.shifted, shifted);
          errors++;
        end
      end
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [bdh_pkg::IDX_W-1:0]      button_index = '0;
  logic                           pin_level = 1'b0;
  logic                           shift_now = 1'b0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [bdh_pkg::IDX_W-1:0]      button_echo;
  logic [2:0]                     event_kind;
  logic                           shift_latched;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [bdh_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [bdh_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  debounce_scoreboard sb;

  // Idling controls for the two sides: odds of 1 in N per draw, 0 for none
  int gap_odds   = 0;
  int stall_odds = 0;
  bit calm       = 1'b0;
  bit long_hold_req = 1'b0;
  int settings_used = 0;
  int cycle_count   = 0;

  button_debounce_hold_events_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .button_index  (button_index),
    .pin_level     (pin_level),
    .shift_now     (shift_now),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .button_echo   (button_echo),
    .event_kind    (event_kind),
    .shift_latched (shift_latched),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one poll word and hold it until the block takes it. An optional
  // idle burst goes in front; the previous word has already been accepted.
  task automatic send_poll(input logic [bdh_pkg::IDX_W-1:0] btn, input logic pin,
                           input logic shift_in);
    if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    button_index <= btn;
    pin_level    <= pin;
    shift_now    <= shift_in;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.predict_poll(btn, pin, shift_in);
  endtask

  // Drop valid and wait for every outstanding event word, then let the
  // pipeline run dry before anything touches the registers.
  task automatic wait_all_events();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bdh_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bdh_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Load both registers; junk goes in the bits above each register's width
  task automatic set_timing(input int unsigned deb, input int unsigned hld);
    logic [bdh_pkg::CFG_DATA_W-1:0] data;
    wait_all_events();
    data = bdh_pkg::CFG_DATA_W'($urandom);
    data[bdh_pkg::DEB_W-1:0] = bdh_pkg::DEB_W'(deb);
    write_reg(bdh_pkg::CFG_DEBOUNCE, data);
    data = bdh_pkg::CFG_DATA_W'($urandom);
    data[bdh_pkg::HOLD_W-1:0] = bdh_pkg::HOLD_W'(hld);
    write_reg(bdh_pkg::CFG_HOLD, data);
    settings_used++;
  endtask

  function automatic int plan_press(int unsigned deb, int unsigned hld);
    case ($urandom_range(0, 3))
      0:       return $urandom_range(1, deb + 1);
      1:       return $urandom_range(1, hld + 1);
      default: return hld + $urandom_range(1, 6);
    endcase
  endfunction

  function automatic int plan_rest(int unsigned deb);
    if ($urandom_range(0, 3) == 0) return 1;
    return $urandom_range(1, deb + 2);
  endfunction

  // Random phase: a few buttons each run press/hold/release scripts with
  // random lengths; one word in ten is noise on any button.
  task automatic run_phase(input int unsigned deb, input int unsigned hld, input int n,
                           input int nbtn, input bit with_pressure);
    logic [bdh_pkg::IDX_W-1:0] btns [4];
    int                        press_left [4];
    int                        rest_left [4];
    int                        k;
    logic                      pin;
    logic [bdh_pkg::IDX_W-1:0] btn;
    set_timing(deb, hld);
    for (int s = 0; s < 4; s++) begin
      btns[s]       = bdh_pkg::IDX_W'($urandom_range(0, bdh_pkg::NUM_BUTTONS - 1));
      press_left[s] = plan_press(deb, hld);
      rest_left[s]  = 0;
    end
    for (int i = 0; i < n; i++) begin
      if (with_pressure && i == n / 4) long_hold_req = 1'b1;
      if (with_pressure && i == n / 2) wait_all_events();
      k = $urandom_range(0, nbtn - 1);
      if ($urandom_range(0, 9) == 0) begin
        btn = bdh_pkg::IDX_W'($urandom);
        pin = 1'($urandom);
      end else begin
        btn = btns[k];
        if (press_left[k] > 0) begin
          pin = 1'b1;
          press_left[k]--;
          if (press_left[k] == 0) rest_left[k] = plan_rest(deb);
        end else begin
          pin = 1'b0;
          rest_left[k]--;
          if (rest_left[k] <= 0) press_left[k] = plan_press(deb, hld);
        end
      end
      send_poll(btn, pin, 1'($urandom));
    end
  endtask

  // Receiver: check each accepted word, then decide the next ready level
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready)
        sb.check_event(button_echo, event_kind, shift_latched);
      if (long_hold_req) begin
        // back-pressure long enough for the pipeline to fill and stall its input
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if (!calm && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $error("timeout after %0d cycles with %0d event words outstanding",
           cycle_count, sb.expected_events.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [bdh_pkg::IDX_W-1:0] marathon_btn;
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset timing first (debounce 5, hold 100)
    send_poll(6'd0, 1'b0, 1'b1);   // idle, released: nothing
    send_poll(6'd0, 1'b1, 1'b1);   // press, capture shift
    send_poll(6'd0, 1'b0, 1'b0);   // release inside the window: ignored

    // Shortest window, hold three polls after press
    set_timing(1, 3);
    send_poll(6'd63, 1'b1, 1'b1);  // press
    send_poll(6'd63, 1'b1, 1'b0);
    send_poll(6'd63, 1'b1, 1'b0);
    send_poll(6'd63, 1'b1, 1'b0);  // hold
    send_poll(6'd63, 1'b1, 1'b1);  // repeat
    send_poll(6'd63, 1'b0, 1'b0);  // late release, lockout
    send_poll(6'd63, 1'b1, 1'b0);  // lockout swallows the press
    send_poll(6'd63, 1'b1, 1'b0);  // press, shift clear
    send_poll(6'd63, 1'b0, 1'b1);  // early release
    send_poll(6'd42, 1'b1, 1'b1);
    send_poll(6'd21, 1'b1, 1'b0);

    // No window at all: release loads zero, so a press may follow at once
    set_timing(0, 3);
    send_poll(6'd5, 1'b1, 1'b1);   // press
    send_poll(6'd5, 1'b0, 1'b0);   // release
    send_poll(6'd5, 1'b1, 1'b0);   // press again straight away
    send_poll(6'd5, 1'b1, 1'b1);
    send_poll(6'd5, 1'b1, 1'b1);
    send_poll(6'd5, 1'b1, 1'b1);   // hold
    send_poll(6'd5, 1'b1, 1'b1);   // repeat
    send_poll(6'd5, 1'b0, 1'b1);   // late release
    send_poll(6'd5, 1'b1, 1'b1);   // press

    // Writes to indexes past the register list must change nothing
    wait_all_events();
    write_reg(bdh_pkg::CFG_IDX_W'(2), bdh_pkg::CFG_DATA_W'($urandom));
    write_reg({bdh_pkg::CFG_IDX_W{1'b1}}, bdh_pkg::CFG_DATA_W'($urandom));

    // Random phases with varied idling on both sides
    gap_odds = 4;  stall_odds = 4;
    run_phase(1, 2, 250, 4, 1'b0);
    gap_odds = 6;  stall_odds = 3;
    run_phase(3, 12, 300, 3, 1'b1);
    gap_odds = 0;  stall_odds = 5;
    run_phase(20, 4, 300, 2, 1'b0);      // hold below debounce
    gap_odds = 3;  stall_odds = 0;
    run_phase(5, 100, 300, 2, 1'b0);
    gap_odds = 5;  stall_odds = 5;
    run_phase($urandom_range(1, 16), $urandom_range(2, 40), 300, 4, 1'b0);
    gap_odds = 8;  stall_odds = 8;
    run_phase(255, 2, 200, 1, 1'b0);     // longest window and lockout

    // Last part, no idling: one button held well past a long hold time
    calm = 1'b1;
    set_timing(1, 300);
    marathon_btn = bdh_pkg::IDX_W'($urandom);
    for (int i = 0; i < 320; i++) send_poll(marathon_btn, 1'b1, 1'($urandom));
    send_poll(marathon_btn, 1'b0, 1'b0);   // late release
    send_poll(marathon_btn, 1'b1, 1'b1);   // lockout
    send_poll(marathon_btn, 1'b1, 1'b1);   // press
    send_poll(marathon_btn, 1'b0, 1'b0);   // early release

    wait_all_events();
    $display("Sent %0d polls, checked %0d event words over %0d timing settings.",
             sb.polls, sb.checked, settings_used);
    $display("Events: none %0d, press %0d, release %0d, hold %0d, repeat %0d, late %0d.",
             sb.kind_seen[bdh_pkg::EV_NONE], sb.kind_seen[bdh_pkg::EV_PRESS],
             sb.kind_seen[bdh_pkg::EV_RELEASE], sb.kind_seen[bdh_pkg::EV_HOLD],
             sb.kind_seen[bdh_pkg::EV_REPEAT], sb.kind_seen[bdh_pkg::EV_LATE_RELEASE]);
    if (sb.errors == 0 && sb.expected_events.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* files.f */
src/bdh_pkg.sv
src/bdh_ram.sv
src/bdh_step.sv
src/button_debounce_hold_events_top.sv
verif/tb_top.sv
